>>> rtl/blp_pkg.sv
// Shared types and constants for the LED blink pattern player.
package blp_pkg;

    localparam int MAX_STEPS  = 8;
    localparam int TIME_BITS  = 32;
    localparam int STEP_SLOTS = 8;
    localparam int IDX_W      = 3;
    localparam int SCNT_W     = 4;
    localparam int PASS_W     = 9;
    localparam int REP_W      = 8;
    localparam int TOT_W      = TIME_BITS + 3;
    localparam int ALU_W      = TIME_BITS + 4;
    localparam int PKW        = TIME_BITS + PASS_W;
    localparam int DIVC_W     = $clog2(TIME_BITS + 1);
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic [SCNT_W-1:0] STEP_LIM =
        SCNT_W'((MAX_STEPS < STEP_SLOTS) ? MAX_STEPS : STEP_SLOTS);

    localparam logic [CFG_IDX_W-1:0] REG_PAIR0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 3'd5;

    localparam logic [PASS_W-1:0] PASS_IDLE = PASS_W'(1);

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_RESTART = 2'd1,
        ACT_JUMP    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_WALK1,
        ST_WRAP,
        ST_SUM,
        ST_DIV,
        ST_KCHK,
        ST_WALK2,
        ST_BASE,
        ST_RESULT
    } t_state;

    typedef logic [TIME_BITS-1:0] t_dur_arr [STEP_SLOTS];

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             borrow;
        logic [ALU_W-1:0] res;
    } t_alu_rsp;

    typedef struct packed {
        logic completed;
        logic active;
        logic led_on;
    } t_result;

endpackage

>>> rtl/blp_alu.sv
// Shared add/subtract unit used by the sequencer for elapsed time, step walks, the pattern sum, division and base.
module blp_alu
    import blp_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W:0] w_sum;

    assign w_sum = {1'b0, i_req.a}
                 + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
                 + {{ALU_W{1'b0}}, i_req.sub};

    assign o_rsp.res    = w_sum[ALU_W-1:0];
    assign o_rsp.borrow = i_req.sub & ~w_sum[ALU_W];

endmodule

>>> rtl/blp_seq.sv
// Sequencer and player state: walks steps, sums the pattern and divides out whole passes.
module blp_seq
    import blp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_action              i_action,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [IDX_W-1:0]     i_new_index,
    input  t_dur_arr             i_dur,
    input  logic [SCNT_W-1:0]    i_cnt,
    input  logic [REP_W-1:0]     i_repeat,
    input  logic                 i_out_free,
    output logic                 o_res_load,
    output t_result              o_res,
    output t_alu_req             o_alu_req,
    input  t_alu_rsp             i_alu_rsp
);

    t_state                r_state, n_state;
    logic [TIME_BITS-1:0]  r_now, n_now;
    logic [TIME_BITS-1:0]  r_base, n_base;
    logic [TIME_BITS-1:0]  r_delta, n_delta;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [PASS_W-1:0]     r_passes, n_passes;
    logic                  r_led, n_led;
    logic                  r_adv, n_adv;
    logic                  r_done, n_done;
    logic [TOT_W-1:0]      r_total, n_total;
    logic [ALU_W-1:0]      r_rem, n_rem;
    logic [TIME_BITS-1:0]  r_quo, n_quo;
    logic [DIVC_W-1:0]     r_cnt, n_cnt;

    logic [SCNT_W-1:0]     w_idx_nxt;
    logic [SCNT_W-1:0]     w_k_nxt;
    logic [ALU_W-1:0]      w_shift;
    logic [PASS_W-1:0]     w_pass_dec;
    logic [PKW-1:0]        w_k_wide;
    logic [PKW-1:0]        w_pm1_wide;
    logic [PKW-1:0]        w_pass_sub;
    logic [SCNT_W-1:0]     w_cnt_m1;

    assign w_idx_nxt  = SCNT_W'(r_idx) + SCNT_W'(1);
    assign w_k_nxt    = SCNT_W'(r_cnt[IDX_W-1:0]) + SCNT_W'(1);
    assign w_shift    = {r_rem[ALU_W-2:0], r_quo[TIME_BITS-1]};
    assign w_pass_dec = (r_passes > PASS_IDLE) ? r_passes - PASS_W'(1) : r_passes;
    assign w_k_wide   = PKW'(r_quo);
    assign w_pm1_wide = PKW'(r_passes) - PKW'(1);
    assign w_pass_sub = PKW'(r_passes) - w_k_wide;
    assign w_cnt_m1   = i_cnt - SCNT_W'(1);

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_base   <= '0;
            r_idx    <= '0;
            r_passes <= PASS_IDLE;
            r_led    <= 1'b0;
            r_done   <= 1'b0;
            r_adv    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_idx    <= n_idx;
            r_passes <= n_passes;
            r_led    <= n_led;
            r_done   <= n_done;
            r_adv    <= n_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now   <= n_now;
        r_delta <= n_delta;
        r_total <= n_total;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
    end

    always_comb begin
        n_state    = r_state;
        n_now      = r_now;
        n_base     = r_base;
        n_delta    = r_delta;
        n_idx      = r_idx;
        n_passes   = r_passes;
        n_led      = r_led;
        n_adv      = r_adv;
        n_done     = r_done;
        n_total    = r_total;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        o_alu_req  = '{sub: 1'b1, a: ALU_W'(r_delta), b: ALU_W'(i_dur[r_idx])};
        o_res_load = 1'b0;
        o_res      = '{completed: r_done, active: (r_passes != PASS_IDLE), led_on: r_led};

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_now  = i_now;
                    n_done = 1'b0;
                    n_adv  = 1'b0;
                    n_state = ST_RESULT;
                    case (i_action)
                        ACT_TICK: begin
                            if (r_passes != PASS_IDLE) begin
                                if (SCNT_W'(r_idx) >= i_cnt) begin
                                    n_idx = w_cnt_m1[IDX_W-1:0];
                                end
                                n_state = ST_DELTA;
                            end
                        end
                        ACT_RESTART: begin
                            n_base   = i_now;
                            n_passes = (i_repeat != '0) ? PASS_W'(i_repeat) + PASS_W'(1)
                                                        : '0;
                            n_idx    = '0;
                            n_led    = 1'b1;
                        end
                        ACT_JUMP: begin
                            n_idx = (SCNT_W'(i_new_index) >= i_cnt) ? w_cnt_m1[IDX_W-1:0]
                                                                     : i_new_index;
                            n_led = ~n_idx[0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DELTA: begin
                o_alu_req = '{sub: 1'b1, a: ALU_W'(r_now), b: ALU_W'(r_base)};
                n_delta   = i_alu_rsp.res[TIME_BITS-1:0];
                n_state   = ST_WALK1;
            end
            ST_WALK1: begin
                // consume whole steps while the elapsed time covers them
                if (!i_alu_rsp.borrow) begin
                    n_delta = i_alu_rsp.res[TIME_BITS-1:0];
                    n_adv   = 1'b1;
                    if (w_idx_nxt >= i_cnt) begin
                        n_idx   = '0;
                        n_state = ST_WRAP;
                    end else begin
                        n_idx = w_idx_nxt[IDX_W-1:0];
                    end
                end else begin
                    n_state = r_adv ? ST_BASE : ST_RESULT;
                end
            end
            ST_WRAP: begin
                if (w_pass_dec == PASS_IDLE) begin
                    n_passes = PASS_IDLE;
                    n_idx    = '0;
                    n_led    = 1'b0;
                    n_done   = 1'b1;
                    n_state  = ST_RESULT;
                end else begin
                    n_passes = w_pass_dec;
                    n_total  = '0;
                    n_cnt    = '0;
                    n_state  = ST_SUM;
                end
            end
            ST_SUM: begin
                o_alu_req = '{sub: 1'b0, a: ALU_W'(r_total),
                              b: ALU_W'(i_dur[r_cnt[IDX_W-1:0]])};
                n_total   = i_alu_rsp.res[TOT_W-1:0];
                n_cnt     = r_cnt + DIVC_W'(1);
                if (w_k_nxt >= i_cnt) begin
                    n_rem   = '0;
                    n_quo   = r_delta;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                o_alu_req = '{sub: 1'b1, a: w_shift, b: ALU_W'(r_total)};
                n_rem     = i_alu_rsp.borrow ? w_shift : i_alu_rsp.res;
                n_quo     = {r_quo[TIME_BITS-2:0], ~i_alu_rsp.borrow};
                n_cnt     = r_cnt + DIVC_W'(1);
                if (r_cnt == DIVC_W'(TIME_BITS - 1)) begin
                    n_state = ST_KCHK;
                end
            end
            ST_KCHK: begin
                n_idx = '0;
                if (r_passes != '0 && w_k_wide >= w_pm1_wide) begin
                    n_passes = PASS_IDLE;
                    n_led    = 1'b0;
                    n_done   = 1'b1;
                    n_state  = ST_RESULT;
                end else begin
                    if (r_passes != '0) begin
                        n_passes = w_pass_sub[PASS_W-1:0];
                    end
                    n_delta = r_rem[TIME_BITS-1:0];
                    n_state = ST_WALK2;
                end
            end
            ST_WALK2: begin
                if (!i_alu_rsp.borrow) begin
                    n_delta = i_alu_rsp.res[TIME_BITS-1:0];
                    n_idx   = w_idx_nxt[IDX_W-1:0];
                    if (w_idx_nxt >= i_cnt) begin
                        n_state = ST_BASE;
                    end
                end else begin
                    n_state = ST_BASE;
                end
            end
            ST_BASE: begin
                // keep leftover time by moving the base back from now
                o_alu_req = '{sub: 1'b1, a: ALU_W'(r_now), b: ALU_W'(r_delta)};
                n_base    = i_alu_rsp.res[TIME_BITS-1:0];
                n_led     = ~r_idx[0];
                n_state   = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/led_blink_pattern_player.sv
// Top level: configuration registers, sequencer, shared unit and output register.
//
//  Channel   Dir  Payload (low bit first)                     Accepted when
//  s_axis    in   tdata: now_time[31:0], new_index[34:32]     s_axis_tvalid & s_axis_tready
//                 tuser: action[1:0]
//  m_axis    out  tdata: led_on[0], active[1], completed[2]   m_axis_tvalid & m_axis_tready
//  cfg       in   i_cfg_idx selects register, i_cfg_data      i_cfg_we
//
// Restart, jump and no-op beats go straight to the result; so does a tick on an inactive player.
// A tick first forms the elapsed time, then walks the steps it covers within the pass.
// A wrap adds the pattern sum over the steps in use and a restoring division of the
// leftover time by that sum, all on the one shared adder.
// The input is not ready while a beat is being worked; the output register holds a
// result until taken, and a new beat is accepted meanwhile.
// Reset is synchronous; it leaves the player inactive with the LED off.
module led_blink_pattern_player
    import blp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // now_time, new_index
    input  logic [1:0]            s_axis_tuser,   // action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // led_on, active, completed
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    logic [CFG_W-1:0]  r_pair [STEP_SLOTS/2];
    logic [SCNT_W-1:0] r_step_count;
    logic [REP_W-1:0]  r_repeat;
    logic              r_out_valid;
    t_result           r_out;

    t_dur_arr          w_dur;
    logic [SCNT_W-1:0] w_cnt;
    logic              w_out_free;
    logic              w_res_load;
    t_result           w_res;
    t_alu_req          w_alu_req;
    t_alu_rsp          w_alu_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < STEP_SLOTS/2; j++) begin
                r_pair[j] <= '0;
            end
            r_step_count <= SCNT_W'(2);
            r_repeat     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PAIR0:  r_pair[0]    <= i_cfg_data;
                REG_PAIR1:  r_pair[1]    <= i_cfg_data;
                REG_PAIR2:  r_pair[2]    <= i_cfg_data;
                REG_PAIR3:  r_pair[3]    <= i_cfg_data;
                REG_STEPS:  r_step_count <= i_cfg_data[SCNT_W-1:0];
                REG_REPEAT: r_repeat     <= i_cfg_data[REP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // durations cut to time width; a zero duration counts as one
    always_comb begin
        for (int j = 0; j < STEP_SLOTS; j++) begin
            w_dur[j] = (j % 2 == 1) ? r_pair[j/2][32 +: TIME_BITS]
                                    : r_pair[j/2][0 +: TIME_BITS];
            if (w_dur[j] == '0) begin
                w_dur[j] = TIME_BITS'(1);
            end
        end
    end

    assign w_cnt = (r_step_count == '0)      ? SCNT_W'(1) :
                   (r_step_count > STEP_LIM) ? STEP_LIM   : r_step_count;

    assign w_out_free = ~r_out_valid | m_axis_tready;

    blp_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (t_action'(s_axis_tuser)),
        .i_now       (s_axis_tdata[TIME_BITS-1:0]),
        .i_new_index (s_axis_tdata[32 +: IDX_W]),
        .i_dur       (w_dur),
        .i_cnt       (w_cnt),
        .i_repeat    (r_repeat),
        .i_out_free  (w_out_free),
        .o_res_load  (w_res_load),
        .o_res       (w_res),
        .o_alu_req   (w_alu_req),
        .i_alu_rsp   (w_alu_rsp)
    );

    blp_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-3){1'b0}}, r_out.completed, r_out.active,
                            r_out.led_on};

endmodule

>>> rtl/blp_chk.sv
// Port-level checker for the LED blink pattern player, bound to the top level.
module blp_chk
    import blp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // completion leaves the player inactive and dark
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1] && !m_axis_tdata[0])
        else $error("completed beat shows active player or lit LED");

    // one beat at a time: input drops ready right after a beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    // a result never appears in the cycle after the input beat
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared before the beat was worked");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

endmodule

bind led_blink_pattern_player blp_chk u_blp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> verif/led_blink_pattern_player_tb.sv
// Self-checking testbench for the LED blink pattern player: stream stimulus, status prediction.
module led_blink_pattern_player_tb;
    import blp_pkg::*;

    typedef struct {
        t_action              act;
        logic [TIME_BITS-1:0] now;
        logic [IDX_W-1:0]     idx;
        bit                   drain_first;   // hold the beat until all status is back
    } blink_cmd_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // now_time[31:0], new_index[34:32]
    logic [1:0]            s_axis_tuser = '0;   // action[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // led_on[0], active[1], completed[2]
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    led_blink_pattern_player dut (.*);

    // Pattern configuration as the player should see it
    logic [CFG_W-1:0]     dur_pairs [4];
    logic [SCNT_W-1:0]    step_cfg;
    logic [REP_W-1:0]     repeat_cfg;
    // Player state
    logic [TIME_BITS-1:0] origin_time;
    logic [IDX_W-1:0]     cur_step;
    logic [PASS_W-1:0]    passes_to_go;
    logic                 led_lit;

    blink_cmd_t           cmd_queue [$];
    t_result              expected_status [$];
    logic [TIME_BITS-1:0] stim_time;
    bit                   quiet;
    int                   send_gap;
    int                   stall_left;
    int                   mismatches;
    int                   items_sent;
    int                   status_checked;
    int                   completions_seen;
    int                   phases_run;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [TIME_BITS-1:0] step_duration(input int i);
        logic [CFG_W-1:0]     p;
        logic [TIME_BITS-1:0] d;
        p = dur_pairs[(i >> 1) & 3];
        d = i[0] ? p[63:32] : p[31:0];
        return (d == 0) ? TIME_BITS'(1) : d;
    endfunction

    function automatic int steps_in_play();
        int c;
        c = step_cfg;
        if (c == 0) c = 1;
        if (c > int'(STEP_LIM)) c = STEP_LIM;
        return c;
    endfunction

    // Returns 1 when this tick ends the final pass
    function automatic bit tick_pattern(input logic [TIME_BITS-1:0] now);
        int                   cnt;
        int                   i;
        int                   j;
        logic [TIME_BITS-1:0] delta;
        logic [63:0]          total;
        logic [63:0]          k;
        cnt = steps_in_play();
        if (passes_to_go == PASS_IDLE) return 1'b0;
        if (cur_step >= cnt) cur_step = IDX_W'(cnt - 1);
        delta = now - origin_time;
        if (delta < step_duration(cur_step)) return 1'b0;
        i = cur_step;
        while (i < cnt && delta >= step_duration(i)) begin
            delta -= step_duration(i);
            i++;
        end
        if (i >= cnt) begin
            i = 0;
            if (passes_to_go > 1) passes_to_go--;
            if (passes_to_go == PASS_IDLE) begin
                cur_step = '0;
                led_lit = 1'b0;
                return 1'b1;
            end
            total = 0;
            for (j = 0; j < cnt; j++) total += 64'(step_duration(j));
            // skip whole passes in one go
            k = 64'(delta) / total;
            if (passes_to_go != 0) begin
                if (k >= 64'(passes_to_go) - 1) begin
                    passes_to_go = PASS_IDLE;
                    cur_step = '0;
                    led_lit = 1'b0;
                    return 1'b1;
                end
                passes_to_go = passes_to_go - PASS_W'(k);
            end
            delta = TIME_BITS'(64'(delta) - k * total);
            while (i < cnt && delta >= step_duration(i)) begin
                delta -= step_duration(i);
                i++;
            end
        end
        cur_step = i[IDX_W-1:0];
        origin_time = now - delta;
        led_lit = ~cur_step[0];
        return 1'b0;
    endfunction

    function automatic void apply_blink_cmd(input blink_cmd_t c);
        t_result r;
        bit      done;
        int      cnt;
        done = 1'b0;
        case (c.act)
            ACT_TICK: begin
                done = tick_pattern(c.now);
            end
            ACT_RESTART: begin
                origin_time = c.now;
                passes_to_go = (repeat_cfg != 0) ? PASS_W'(repeat_cfg) + 1'b1 : '0;
                cur_step = '0;
                led_lit = 1'b1;
            end
            ACT_JUMP: begin
                cnt = steps_in_play();
                cur_step = (c.idx >= cnt) ? IDX_W'(cnt - 1) : c.idx;
                led_lit = ~cur_step[0];
            end
            default: ;
        endcase
        r.led_on = led_lit;
        r.active = (passes_to_go != PASS_IDLE);
        r.completed = done;
        expected_status.push_back(r);
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 40) $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Sender: present the oldest pending beat, advance on handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_blink_cmd(cmd_queue.pop_front());
                items_sent++;
                send_gap = pick_gap();
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_queue.size() > 0 &&
                             !(cmd_queue[0].drain_first && expected_status.size() > 0)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({cmd_queue[0].idx, cmd_queue[0].now});
                    s_axis_tuser  <= cmd_queue[0].act;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each status beat, stall at random after it
    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("status beat with nothing expected");
                end else begin
                    e = expected_status.pop_front();
                    status_checked++;
                    if (m_axis_tdata[0] !== e.led_on)
                        report_mismatch($sformatf("led_on %b, expected %b",
                                                  m_axis_tdata[0], e.led_on));
                    if (m_axis_tdata[1] !== e.active)
                        report_mismatch($sformatf("active %b, expected %b",
                                                  m_axis_tdata[1], e.active));
                    if (m_axis_tdata[2] !== e.completed)
                        report_mismatch($sformatf("completed %b, expected %b",
                                                  m_axis_tdata[2], e.completed));
                    if (e.completed) completions_seen++;
                end
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic push_cmd(input t_action act, input logic [TIME_BITS-1:0] now,
                            input logic [IDX_W-1:0] idx, input bit drain_first = 1'b0);
        blink_cmd_t c;
        c.act = act;
        c.now = now;
        c.idx = idx;
        c.drain_first = drain_first;
        cmd_queue.push_back(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_PAIR0, REG_PAIR1, REG_PAIR2, REG_PAIR3: dur_pairs[idx] = val;
            REG_STEPS:  step_cfg = val[SCNT_W-1:0];
            REG_REPEAT: repeat_cfg = val[REP_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every queued beat has gone in and its status has come back
    task automatic drain();
        while (cmd_queue.size() != 0 || expected_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [TIME_BITS-1:0] rand_duration(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0) return (r < 10) ? '0 : TIME_BITS'($urandom_range(1, 12));
        if (r < 15) return '0;
        if (r < 30) return '1;
        if (r < 60) return TIME_BITS'($urandom_range(1, 5000));
        return TIME_BITS'($urandom());
    endfunction

    task automatic set_random_config(input int mode);
        int i;
        int r;
        for (i = 0; i < 4; i++)
            write_reg(CFG_IDX_W'(i), {rand_duration(mode), rand_duration(mode)});
        r = $urandom_range(0, 99);
        write_reg(REG_STEPS, CFG_W'((r < 6) ? 0 : (r < 12) ? $urandom_range(9, 15) :
                                    (r < 30) ? 8 : $urandom_range(1, 8)));
        r = $urandom_range(0, 5);
        write_reg(REG_REPEAT, CFG_W'((r == 0) ? 0 : (r == 1) ? 255 :
                                     (r == 2) ? $urandom_range(0, 255) : r - 2));
    endtask

    function automatic logic [TIME_BITS-1:0] rand_advance(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0) begin
            if (r < 60) return TIME_BITS'($urandom_range(0, 8));
            if (r < 85) return TIME_BITS'($urandom_range(0, 60));
            if (r < 95) return TIME_BITS'($urandom_range(0, 3000));
            return TIME_BITS'($urandom());
        end
        if (r < 40) return TIME_BITS'($urandom_range(0, 6000));
        return TIME_BITS'($urandom());
    endfunction

    // Restart, then mostly ticks on a rising clock, with jumps and noise mixed in
    task automatic fill_random_phase(input int n, input int mode, input bit force_drain);
        int i;
        int r;
        stim_time = $urandom();
        push_cmd(ACT_RESTART, stim_time, IDX_W'($urandom()));
        for (i = 1; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                stim_time += rand_advance(mode);
                push_cmd(ACT_TICK, stim_time, IDX_W'($urandom()),
                         (force_drain && i == 10) || $urandom_range(0, 39) == 0);
            end else if (r < 80) begin
                push_cmd(ACT_JUMP, stim_time, IDX_W'($urandom()));
            end else if (r < 84) begin
                push_cmd(ACT_NONE, $urandom(), IDX_W'($urandom()));
            end else if (r < 90) begin
                push_cmd(ACT_RESTART, stim_time, IDX_W'($urandom()));
            end else begin
                push_cmd(ACT_TICK, $urandom(), IDX_W'($urandom()));
            end
        end
    endtask

    initial begin
        int ph;
        for (int i = 0; i < 4; i++) dur_pairs[i] = '0;
        step_cfg = SCNT_W'(2);
        repeat_cfg = '0;
        origin_time = '0;
        cur_step = '0;
        passes_to_go = PASS_IDLE;
        led_lit = 1'b0;
        quiet = 1'b0;
        send_gap = 0;
        stall_left = 0;
        mismatches = 0;
        items_sent = 0;
        status_checked = 0;
        completions_seen = 0;
        phases_run = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // After reset: idle tick, jump and no-op, then a forever pattern of unit steps
        push_cmd(ACT_TICK, '0, '0);
        push_cmd(ACT_JUMP, '0, 3'd7);
        push_cmd(ACT_NONE, '1, 3'd7);
        push_cmd(ACT_RESTART, 32'd100, '0);
        push_cmd(ACT_TICK, 32'd100, '0);
        push_cmd(ACT_TICK, 32'd101, '0);
        push_cmd(ACT_TICK, '1, '0);
        push_cmd(ACT_JUMP, '1, 3'd5);
        push_cmd(ACT_TICK, '0, '0);
        drain();

        // Zero and all-ones durations, step count above the limit, a single pass with time wrapping
        write_reg(REG_PAIR0, {32'hFFFF_FFFF, 32'h0});
        write_reg(REG_PAIR1, {32'd3, 32'd2});
        write_reg(REG_PAIR2, '1);
        write_reg(REG_PAIR3, {32'd5, 32'd0});
        write_reg(REG_STEPS, CFG_W'(15));
        write_reg(REG_REPEAT, CFG_W'(1));
        push_cmd(ACT_RESTART, 32'hFFFF_FFFE, '0);
        push_cmd(ACT_TICK, 32'hFFFF_FFFF, '0);
        push_cmd(ACT_JUMP, 32'hFFFF_FFFF, 3'd7);
        push_cmd(ACT_TICK, 32'd4, '0);
        push_cmd(ACT_TICK, 32'd10, '0);
        drain();

        // Step count of zero, most repeats, whole run finished by one late tick
        write_reg(REG_PAIR0, CFG_W'(7));
        write_reg(REG_STEPS, '0);
        write_reg(REG_REPEAT, CFG_W'(255));
        push_cmd(ACT_RESTART, '0, '0);
        push_cmd(ACT_TICK, 32'd2100, '0);
        push_cmd(ACT_JUMP, 32'd2100, 3'd7);
        drain();

        // Index left beyond a shrunken step count gets clamped by the next tick
        write_reg(REG_STEPS, CFG_W'(8));
        write_reg(REG_REPEAT, '0);
        push_cmd(ACT_RESTART, '0, '0);
        push_cmd(ACT_JUMP, '0, 3'd7);
        drain();
        write_reg(REG_STEPS, CFG_W'(2));
        push_cmd(ACT_TICK, '0, '0);
        push_cmd(ACT_TICK, 32'd1000, '0, 1'b1);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            quiet = (ph % 3 == 1);
            set_random_config((ph % 4 == 3) ? 1 : 0);
            fill_random_phase(50, (ph % 4 == 3) ? 1 : 0, ph == 0);
            drain();
            phases_run++;
        end

        quiet = 1'b0;
        repeat (70) @(posedge i_clk);
        $display("Covered %0d beats in %0d random configurations plus directed cases",
                 items_sent, phases_run);
        $display("Checked %0d status beats, %0d of them ending a pattern run",
                 status_checked, completions_seen);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d beats pending", cmd_queue.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
